// ===== rtl/core/ftrsa_pkg.sv =====
// Shared types and constants for the fence-tagged ring slot allocator.
// No dependencies; imported by every module of the block.
package ftrsa_pkg;

  localparam int MAX_SLOTS  = 8;
  localparam int SLOT_W     = 3;   // slot index width
  localparam int CNT_W      = 4;   // slot count / busy count width
  localparam int TAG_W      = 32;
  localparam int BYTES_W    = 20;
  localparam int OFFS_W     = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int FUNC_W     = 2;

  localparam logic [FUNC_W-1:0] FUNC_REFRESH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ASSIGN  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUBMIT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_EXT_TAGS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 2'd2;

  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUBMIT,
    ST_WALK,
    ST_ASSIGN,
    ST_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input item, clear walk state
    logic submit;   // mark current slot busy, stamp counter tag unless ext tags
    logic walk;     // visit one slot
    logic refresh;  // walk frees reached slots (else count only)
    logic alloc;    // pick next slot and stamp it if free
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_last;  // walk index is on the last active slot
  } dp_stat_t;

endpackage

// ===== rtl/core/ftrsa_ctrl.sv =====
// Sequencing state machine for the ring slot allocator.
// Depends on ftrsa_pkg; drives ftrsa_dp through ctrl_cmd_t.
module ftrsa_ctrl
  import ftrsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [FUNC_W-1:0] func_i,
  input  dp_stat_t          stat_i,
  output ctrl_cmd_t         cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  state_e state_q, state_d;
  logic   submit_q, submit_d;
  logic   assign_q, assign_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      submit_q <= 1'b0;
      assign_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      submit_q <= submit_d;
      assign_q <= assign_d;
    end
  end

  // next state
  always_comb begin
    state_d  = state_q;
    submit_d = submit_q;
    assign_d = assign_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          submit_d = (func_i == FUNC_SUBMIT);
          assign_d = (func_i == FUNC_ASSIGN);
          state_d  = (func_i == FUNC_SUBMIT) ? ST_SUBMIT : ST_WALK;
        end
      end
      ST_SUBMIT: state_d = ST_WALK;
      ST_WALK: begin
        if (stat_i.walk_last) state_d = assign_q ? ST_ASSIGN : ST_DONE;
      end
      ST_ASSIGN: state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_SUBMIT: cmd_o.submit = 1'b1;
      ST_WALK: begin
        cmd_o.walk    = 1'b1;
        cmd_o.refresh = !submit_q;
      end
      ST_ASSIGN: cmd_o.alloc = 1'b1;
      ST_DONE:   done_o = 1'b1;
      default:   busy_o = 1'b1;
    endcase
  end

endmodule

// ===== rtl/core/ftrsa_dp.sv =====
// Datapath of the ring slot allocator: config registers, slot marks and
// tags, round-robin pointers, tag counter and result registers. Uses ftrsa_pkg.
module ftrsa_dp
  import ftrsa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_cmd_t             cmd_i,
  output dp_stat_t              stat_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [TAG_W-1:0]      completed_tag_i,
  input  logic [TAG_W-1:0]      issued_tag_i,
  input  logic                  null_render_i,
  output logic                  status_o,
  output logic [SLOT_W-1:0]     slot_index_o,
  output logic [OFFS_W-1:0]     slot_offset_o,
  output logic [TAG_W-1:0]      stamped_tag_o,
  output logic [CNT_W-1:0]      in_use_o
);

  // configuration
  logic               ext_q;
  logic [CNT_W-1:0]   count_q;
  logic [BYTES_W-1:0] bytes_q;

  // slot state
  logic [MAX_SLOTS-1:0] busy_q, busy_d;
  logic [TAG_W-1:0]     tags_q [MAX_SLOTS];
  logic [SLOT_W-1:0]    cur_q, cur_d;
  logic [SLOT_W-1:0]    next_q, next_d;
  logic [TAG_W-1:0]     ctr_q, ctr_d;

  // per-item working registers
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic              status_q, status_d;
  logic [TAG_W-1:0]  stamped_q, stamped_d;
  logic [TAG_W-1:0]  comp_q;
  logic [TAG_W-1:0]  iss_q;
  logic              null_q;

  logic [CNT_W-1:0]  act;
  logic [SLOT_W-1:0] pick;
  logic [CNT_W-1:0]  pick_inc;
  logic              pick_free;
  logic [SLOT_W-1:0] rd_addr;
  logic [TAG_W-1:0]  rd_tag;
  logic [TAG_W-1:0]  diff;
  logic              clr;
  logic              still_busy;
  logic              tag_we;
  logic [SLOT_W-1:0] tag_waddr;
  logic [TAG_W-1:0]  tag_wdata;
  logic [TAG_W-1:0]  new_tag;

  // effective slot count: 0 acts as 1, clamp to ring size
  always_comb begin
    if (count_q == '0) act = CNT_W'(1);
    else if (count_q > CNT_W'(MAX_SLOTS)) act = CNT_W'(MAX_SLOTS);
    else act = count_q;
  end

  assign pick      = ({1'b0, next_q} < act) ? next_q : '0;
  assign pick_inc  = {1'b0, pick} + CNT_W'(1);
  assign pick_free = !busy_q[pick];
  assign new_tag   = ext_q ? iss_q : ctr_q;

  assign rd_addr = cmd_i.walk ? idx_q : cur_q;
  assign rd_tag  = tags_q[rd_addr];

  // wrap-safe: reached when completed - tag is non-negative
  assign diff       = comp_q - rd_tag;
  assign clr        = cmd_i.refresh && busy_q[idx_q] && (null_q || !diff[TAG_W-1]);
  assign still_busy = busy_q[idx_q] && !clr;

  assign stat_o.walk_last = ({1'b0, idx_q} == (act - CNT_W'(1)));

  always_comb begin
    busy_d    = busy_q;
    cur_d     = cur_q;
    next_d    = next_q;
    ctr_d     = ctr_q;
    idx_d     = idx_q;
    used_d    = used_q;
    status_d  = status_q;
    stamped_d = stamped_q;
    tag_we    = 1'b0;
    tag_waddr = cur_q;
    tag_wdata = ctr_q;

    if (cmd_i.load) begin
      idx_d     = '0;
      used_d    = '0;
      status_d  = 1'b0;
      stamped_d = '0;
    end

    if (cmd_i.submit) begin
      busy_d[cur_q] = 1'b1;
      if (!ext_q) begin
        tag_we    = 1'b1;
        ctr_d     = ctr_q + TAG_W'(1);
        stamped_d = ctr_q;
      end else begin
        stamped_d = rd_tag;
      end
    end

    if (cmd_i.walk) begin
      if (clr) busy_d[idx_q] = 1'b0;
      used_d = used_q + CNT_W'(still_busy);
      idx_d  = idx_q + SLOT_W'(1);
    end

    if (cmd_i.alloc) begin
      if (pick_free) begin
        tag_we    = 1'b1;
        tag_waddr = pick;
        tag_wdata = new_tag;
        stamped_d = new_tag;
        cur_d     = pick;
        next_d    = (pick_inc == act) ? '0 : pick_inc[SLOT_W-1:0];
      end else begin
        status_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q     <= 1'b0;
      count_q   <= SLOT_COUNT_RST;
      bytes_q   <= '0;
      busy_q    <= '0;
      cur_q     <= '0;
      next_q    <= '0;
      ctr_q     <= '0;
      idx_q     <= '0;
      used_q    <= '0;
      status_q  <= 1'b0;
      stamped_q <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) tags_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_EXT_TAGS:   ext_q   <= cfg_data_i[0];
          CFG_SLOT_COUNT: count_q <= cfg_data_i[CNT_W-1:0];
          CFG_SLOT_BYTES: bytes_q <= cfg_data_i[BYTES_W-1:0];
          default: ;
        endcase
      end
      busy_q    <= busy_d;
      cur_q     <= cur_d;
      next_q    <= next_d;
      ctr_q     <= ctr_d;
      idx_q     <= idx_d;
      used_q    <= used_d;
      status_q  <= status_d;
      stamped_q <= stamped_d;
      if (tag_we) tags_q[tag_waddr] <= tag_wdata;
    end
  end

  // item fields, held for the walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      comp_q <= completed_tag_i;
      iss_q  <= issued_tag_i;
      null_q <= null_render_i;
    end
  end

  assign status_o      = status_q;
  assign slot_index_o  = cur_q;
  assign slot_offset_o = OFFS_W'({{(OFFS_W-SLOT_W){1'b0}}, cur_q} *
                                 {{(OFFS_W-BYTES_W){1'b0}}, bytes_q});
  assign stamped_tag_o = stamped_q;
  assign in_use_o      = used_q;

endmodule

// ===== rtl/core/fence_tagged_ring_slot_allocator.sv =====
// Top level of the fence-tagged ring slot allocator.
// Instantiates ftrsa_ctrl and ftrsa_dp; uses ftrsa_pkg.
//
// An item is taken when start is high and busy is low; busy stays high until
// its single result has been shown. The result is on the output ports for one
// cycle with result_valid_o high and cannot be held off, so the receiver must
// take it then. Every item walks the active slots (slot_count clamped to 1..8)
// one per cycle. A submit first marks the current slot busy, an assign picks
// a slot after the walk, and the block takes the next item only after the
// result has been shown. The config port is always ready; write it only while
// busy is low and no item is in flight.
module fence_tagged_ring_slot_allocator
  import ftrsa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [FUNC_W-1:0]     func_i,
  input  logic [TAG_W-1:0]      completed_tag_i,
  input  logic [TAG_W-1:0]      issued_tag_i,
  input  logic                  null_render_i,
  output logic                  result_valid_o,
  output logic                  status_o,
  output logic [SLOT_W-1:0]     slot_index_o,
  output logic [OFFS_W-1:0]     slot_offset_o,
  output logic [TAG_W-1:0]      stamped_tag_o,
  output logic [CNT_W-1:0]      in_use_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = 1'b1;

  ftrsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (result_valid_o)
  );

  ftrsa_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .completed_tag_i (completed_tag_i),
    .issued_tag_i    (issued_tag_i),
    .null_render_i   (null_render_i),
    .status_o        (status_o),
    .slot_index_o    (slot_index_o),
    .slot_offset_o   (slot_offset_o),
    .stamped_tag_o   (stamped_tag_o),
    .in_use_o        (in_use_o)
  );

endmodule

// ===== rtl/core/ftrsa_chk.sv =====
// Port-level checker for fence_tagged_ring_slot_allocator, bound to the top.
// Uses ftrsa_pkg for widths.
module ftrsa_chk
  import ftrsa_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input logic              status_o,
  input logic [TAG_W-1:0]  stamped_tag_o,
  input logic [CNT_W-1:0]  in_use_o
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after item accepted");

  // one result per item: strobes never back to back
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held two cycles");

  // a result only comes while an item is in flight
  a_result_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result shown while idle");

  // refused assign stamps nothing
  a_refused_no_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> stamped_tag_o == '0)
    else $error("refused assign reports a tag");

  // busy count bounded by ring size
  a_in_use_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> in_use_o <= CNT_W'(MAX_SLOTS))
    else $error("in_use beyond ring size");

endmodule

bind fence_tagged_ring_slot_allocator ftrsa_chk u_ftrsa_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .stamped_tag_o  (stamped_tag_o),
  .in_use_o       (in_use_o)
);

// ===== dv/tb.sv =====
// Testbench for fence_tagged_ring_slot_allocator: directed and random items,
// configuration changes between phases, and an item-level result predictor.
// Depends on ftrsa_pkg and the fence_tagged_ring_slot_allocator RTL.
`timescale 1ns / 1ps

module tb;
  import ftrsa_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;  // unused code, behaves as refresh
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PHASE_ITEMS  = 50;

  typedef struct {
    bit                    is_cfg;
    logic [FUNC_W-1:0]     func;
    logic [TAG_W-1:0]      completed;
    logic [TAG_W-1:0]      issued;
    logic                  nullr;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int unsigned           gap;
  } alloc_req_t;

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] slot_idx;
    logic [OFFS_W-1:0] offset;
    logic [TAG_W-1:0]  stamped;
    logic [CNT_W-1:0]  in_use;
  } slot_result_t;

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  start           = 1'b0;
  logic                  busy;
  logic [FUNC_W-1:0]     func_i          = '0;
  logic [TAG_W-1:0]      completed_tag_i = '0;
  logic [TAG_W-1:0]      issued_tag_i    = '0;
  logic                  null_render_i   = 1'b0;
  logic                  result_valid_o;
  logic                  status_o;
  logic [SLOT_W-1:0]     slot_index_o;
  logic [OFFS_W-1:0]     slot_offset_o;
  logic [TAG_W-1:0]      stamped_tag_o;
  logic [CNT_W-1:0]      in_use_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  fence_tagged_ring_slot_allocator DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .completed_tag_i(completed_tag_i),
    .issued_tag_i   (issued_tag_i),
    .null_render_i  (null_render_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .slot_offset_o  (slot_offset_o),
    .stamped_tag_o  (stamped_tag_o),
    .in_use_o       (in_use_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Pending stimulus and expected results
  alloc_req_t   req_q[$];
  slot_result_t expected_slot_q[$];
  alloc_req_t   live_req;
  alloc_req_t   live_cfg;

  // Predictor state
  logic              slot_busy [MAX_SLOTS];
  logic [TAG_W-1:0]  slot_tag  [MAX_SLOTS];
  logic [SLOT_W-1:0] cur_slot;
  logic [SLOT_W-1:0] nxt_slot;
  logic [TAG_W-1:0]  tag_ctr;
  logic              ext_tags;
  logic [CNT_W-1:0]  slot_cnt;
  logic [BYTES_W-1:0] slot_bytes;

  int unsigned fail_cnt, checked_cnt, item_cnt, cfg_cnt;
  int unsigned assign_cnt, refused_cnt, submit_cnt;
  int unsigned gap_left, quiet_cnt, cyc_cnt;
  bit          drv_hold;

  // Stimulus-side view of the tag streams
  logic        gen_ext;
  logic [TAG_W-1:0] gen_ctr, gen_issue;
  bit          gap_on;
  int unsigned gen_items;

  logic [CNT_W-1:0] count_plan [10] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3,
                                       4'd2, 4'd5, 4'd9, 4'd7, 4'd4};
  logic             ext_plan   [10] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1,
                                       1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned active_slots();
    if (slot_cnt == 0) return 1;
    if (slot_cnt > MAX_SLOTS) return MAX_SLOTS;
    return slot_cnt;
  endfunction

  function automatic logic [CNT_W-1:0] busy_in_ring();
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < active_slots(); i++) if (slot_busy[i]) c++;
    return c;
  endfunction

  // Free every busy active slot whose tag the completed tag has reached (signed wrap compare)
  function automatic logic [CNT_W-1:0] retire_reached(logic [TAG_W-1:0] completed,
                                                      logic nullr);
    logic [TAG_W-1:0] diff;
    for (int i = 0; i < active_slots(); i++) begin
      diff = completed - slot_tag[i];
      if (slot_busy[i] && (nullr || !diff[TAG_W-1])) slot_busy[i] = 1'b0;
    end
    return busy_in_ring();
  endfunction

  function automatic slot_result_t predict_alloc(alloc_req_t rq);
    slot_result_t r;
    int unsigned  n, pick;
    logic [42:0]  prod;
    r = '0;
    n = active_slots();
    case (rq.func)
      FUNC_ASSIGN: begin
        assign_cnt++;
        pick = (nxt_slot < n) ? nxt_slot : 0;
        r.in_use = retire_reached(rq.completed, rq.nullr);
        if (slot_busy[pick]) begin
          r.status = 1'b1;
          refused_cnt++;
        end else begin
          r.stamped = ext_tags ? rq.issued : tag_ctr;
          slot_tag[pick] = r.stamped;
          cur_slot = SLOT_W'(pick);
          nxt_slot = SLOT_W'((pick + 1) % n);
        end
      end
      FUNC_SUBMIT: begin
        submit_cnt++;
        if (!ext_tags) begin
          slot_tag[cur_slot] = tag_ctr;
          tag_ctr++;
        end
        slot_busy[cur_slot] = 1'b1;
        r.stamped = slot_tag[cur_slot];
        r.in_use  = busy_in_ring();
      end
      default: r.in_use = retire_reached(rq.completed, rq.nullr);
    endcase
    prod       = cur_slot * slot_bytes;
    r.slot_idx = cur_slot;
    r.offset   = prod[OFFS_W-1:0];
    return r;
  endfunction

  // Driver: presents pending items and register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start       <= 1'b0;
      cfg_valid_i <= 1'b0;
      gap_left    = 0;
      quiet_cnt   = 0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_busy[i] = 1'b0;
        slot_tag[i]  = '0;
      end
      cur_slot   = '0;
      nxt_slot   = '0;
      tag_ctr    = '0;
      ext_tags   = 1'b0;
      slot_cnt   = SLOT_COUNT_RST;
      slot_bytes = '0;
    end else begin
      drv_hold = 1'b0;
      if (start) begin
        if (!busy) begin
          expected_slot_q.push_back(predict_alloc(live_req));
          item_cnt++;
        end else drv_hold = 1'b1;
      end
      if (cfg_valid_i) begin
        if (cfg_ready_o) begin
          cfg_cnt++;
          case (live_cfg.cfg_idx)
            CFG_EXT_TAGS:   ext_tags   = live_cfg.cfg_data[0];
            CFG_SLOT_COUNT: slot_cnt   = live_cfg.cfg_data[CNT_W-1:0];
            CFG_SLOT_BYTES: slot_bytes = live_cfg.cfg_data[BYTES_W-1:0];
            default: ;
          endcase
        end else drv_hold = 1'b1;
      end
      if (busy || start || expected_slot_q.size() != 0) quiet_cnt = 0;
      else quiet_cnt++;

      if (!drv_hold) begin
        if (gap_left != 0) begin
          gap_left--;
          start       <= 1'b0;
          cfg_valid_i <= 1'b0;
        end else if (req_q.size() == 0) begin
          start       <= 1'b0;
          cfg_valid_i <= 1'b0;
        end else if (req_q[0].gap != 0) begin
          gap_left     = req_q[0].gap - 1;
          req_q[0].gap = 0;
          start       <= 1'b0;
          cfg_valid_i <= 1'b0;
        end else if (req_q[0].is_cfg) begin
          start <= 1'b0;
          // registers change only with the block idle and nothing outstanding
          if (quiet_cnt >= 2 && !busy && expected_slot_q.size() == 0) begin
            live_cfg = req_q.pop_front();
            cfg_valid_i <= 1'b1;
            cfg_index_i <= live_cfg.cfg_idx;
            cfg_data_i  <= live_cfg.cfg_data;
          end else cfg_valid_i <= 1'b0;
        end else begin
          live_req = req_q.pop_front();
          start           <= 1'b1;
          cfg_valid_i     <= 1'b0;
          func_i          <= live_req.func;
          completed_tag_i <= live_req.completed;
          issued_tag_i    <= live_req.issued;
          null_render_i   <= live_req.nullr;
        end
      end
    end
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // Monitor: every result strobe is compared with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_slot_q.size() == 0) begin
        $display("%0t: result with no item outstanding", $time);
        fail_cnt++;
      end else begin
        slot_result_t want;
        want = expected_slot_q.pop_front();
        checked_cnt++;
        check_field("status",      want.status,   status_o);
        check_field("slot_index",  want.slot_idx, slot_index_o);
        check_field("slot_offset", want.offset,   slot_offset_o);
        check_field("stamped_tag", want.stamped,  stamped_tag_o);
        check_field("in_use",      want.in_use,   in_use_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cyc_cnt, expected_slot_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    int unsigned r;
    if (!gap_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 6);
    return $urandom_range(15, 60);
  endfunction

  task automatic add_item(logic [FUNC_W-1:0] func, logic [TAG_W-1:0] completed,
                          logic [TAG_W-1:0] issued, logic nullr);
    alloc_req_t rq;
    rq = '{is_cfg: 1'b0, func: func, completed: completed, issued: issued, nullr: nullr,
           cfg_idx: '0, cfg_data: '0, gap: draw_gap()};
    req_q.push_back(rq);
    gen_items++;
    if (func == FUNC_SUBMIT && !gen_ext) gen_ctr++;
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    alloc_req_t rq;
    rq = '{is_cfg: 1'b1, func: FUNC_REFRESH, completed: '0, issued: '0, nullr: 1'b0,
           cfg_idx: idx, cfg_data: data, gap: 0};
    req_q.push_back(rq);
    if (idx == CFG_EXT_TAGS) gen_ext = data[0];
  endtask

  // Completed tag close behind the newest stamped tag, so assigns are both taken and refused
  function automatic logic [TAG_W-1:0] near_tag();
    return (gen_ext ? gen_issue : gen_ctr) - $urandom_range(0, 5);
  endfunction

  function automatic logic [TAG_W-1:0] next_issue();
    gen_issue = gen_issue + $urandom_range(1, 3);
    return gen_issue;
  endfunction

  initial begin
    int unsigned mark;
    gen_ext   = 1'b0;
    gen_ctr   = '0;
    gen_issue = '0;
    gen_items = 0;
    gap_on    = 1'b1;

    // Directed: submit before any assign, refused assign, wrap compare, null render
    add_item(FUNC_REFRESH, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_item(FUNC_SUBMIT,  32'h0000_0000, 32'h0000_0000, 1'b0);
    add_item(FUNC_ASSIGN,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_item(FUNC_ASSIGN,  32'h0000_0000, 32'h0000_0000, 1'b0);
    add_item(FUNC_SUBMIT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_item(FUNC_ASSIGN,  32'h0000_0000, 32'h5555_5555, 1'b0);
    add_item(FUNC_SUBMIT,  32'hAAAA_AAAA, 32'h0000_0000, 1'b0);
    add_item(FUNC_SPARE,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    add_item(FUNC_REFRESH, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    add_cfg(CFG_SLOT_BYTES, 20'hFFFFF);
    add_cfg(CFG_EXT_TAGS,   20'd1);
    add_cfg(CFG_SLOT_COUNT, 20'd3);
    add_item(FUNC_ASSIGN,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_item(FUNC_SUBMIT,  32'h0000_0000, 32'h0000_0000, 1'b0);
    add_item(FUNC_ASSIGN,  32'hFFFF_FFFE, 32'h0000_0000, 1'b0);
    add_item(FUNC_SUBMIT,  32'h0000_0000, 32'h0000_0000, 1'b0);
    add_item(FUNC_REFRESH, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_item(FUNC_ASSIGN,  32'h8000_0000, 32'h8000_0000, 1'b0);
    add_item(FUNC_SUBMIT,  32'h0000_0000, 32'h0000_0000, 1'b0);
    add_item(FUNC_REFRESH, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_item(FUNC_REFRESH, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    // shrink the ring below the next slot: assign wraps to slot 0
    add_cfg(CFG_SLOT_COUNT, 20'd2);
    add_item(FUNC_ASSIGN,  32'h0000_0000, 32'h1234_5678, 1'b0);
    add_item(FUNC_SUBMIT,  32'h0000_0000, 32'h0000_0000, 1'b0);

    // Random phases: mostly refresh/assign/submit sequences, some noise
    for (int ph = 0; ph < 10; ph++) begin
      gap_on = (ph % 3) != 2;
      add_cfg(CFG_SLOT_COUNT, CFG_DATA_W'(count_plan[ph]));
      add_cfg(CFG_EXT_TAGS,   CFG_DATA_W'(ext_plan[ph]));
      case (ph)
        0:       add_cfg(CFG_SLOT_BYTES, 20'hFFFFF);
        1:       add_cfg(CFG_SLOT_BYTES, 20'h00000);
        2:       add_cfg(CFG_SLOT_BYTES, 20'h00001);
        default: add_cfg(CFG_SLOT_BYTES, CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
      endcase
      case ($urandom_range(0, 2))
        0:       gen_issue = 32'hFFFF_FFF0;
        1:       gen_issue = 32'h7FFF_FFF0;
        default: gen_issue = $urandom;
      endcase
      if ($urandom_range(0, 1)) add_item(FUNC_REFRESH, $urandom, $urandom, 1'b1);
      mark = gen_items;
      while (gen_items - mark < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 80) begin
          if ($urandom_range(0, 3) == 0)
            add_item(FUNC_REFRESH, near_tag(), $urandom, $urandom_range(0, 19) == 0);
          add_item(FUNC_ASSIGN, near_tag(), next_issue(), $urandom_range(0, 19) == 0);
          add_item(FUNC_SUBMIT, $urandom, $urandom, 1'($urandom_range(0, 1)));
        end else begin
          add_item(FUNC_W'($urandom_range(0, 3)), $urandom, $urandom,
                   1'($urandom_range(0, 1)));
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || start || cfg_valid_i || expected_slot_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d items over %0d register writes: %0d assigns (%0d refused), %0d submits",
             item_cnt, cfg_cnt, assign_cnt, refused_cnt, submit_cnt);
    $display("Checked %0d results, %0d field mismatches", checked_cnt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
